/* src/rph_pkg.sv */
// Shared types and constants for the radial position histogram.
// Used by rph_div, radial_position_histogram and its testbench; no dependencies.
package rph_pkg;

	localparam int POS_W     = 32;
	localparam int WIDTH_W   = 32;
	localparam int BCNT_W    = 9;
	localparam int RIDX_W    = 8;
	localparam int OUT_IDX_W = 8;
	localparam int OUT_CNT_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 1'b1;

	typedef enum logic [1:0] {
		OP_ACC   = 2'd0,
		OP_READ  = 2'd1,
		OP_RDCLR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_READ  = 6'b001000,
		ST_MOD   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_MUL  = 4'b0010,
		D_CMP  = 4'b0100,
		D_STEP = 4'b1000
	} div_state_t;

	typedef struct packed {
		logic done;
		logic hit;
	} div_stat_t;

endpackage

/* src/rph_div.sv */
// Range check and bin index search: magnitude against width*limit, then a
// restoring quotient of one bit per cycle. Depends on rph_pkg.
module rph_div #(
	parameter int IDX_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rph_pkg::POS_W-1:0]    mag,
	input  logic [rph_pkg::WIDTH_W-1:0]  width,
	input  logic [IDX_W:0]               lim,
	output rph_pkg::div_stat_t           stat,
	output logic [IDX_W-1:0]             quot
);

	localparam int LIM_W  = IDX_W + 1;
	localparam int PROD_W = rph_pkg::WIDTH_W + LIM_W;
	localparam int DSH_W  = rph_pkg::WIDTH_W + IDX_W;
	localparam int STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

	rph_pkg::div_state_t st_q;
	logic                          done_q;
	logic                          hit_q;
	logic [rph_pkg::POS_W-1:0]     rem_q;
	logic [rph_pkg::WIDTH_W-1:0]   width_q;
	logic [LIM_W-1:0]              lim_q;
	logic [PROD_W-1:0]             prod_q;
	logic [DSH_W-1:0]              dsh_q;
	logic [STEP_W-1:0]             step_q;
	logic [IDX_W-1:0]              quot_q;
	logic                          in_rng;
	logic                          ge;

	assign in_rng = PROD_W'(rem_q) < prod_q;
	assign ge     = DSH_W'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= rph_pkg::D_IDLE;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				rph_pkg::D_IDLE: begin
					if (start) st_q <= rph_pkg::D_MUL;
				end
				rph_pkg::D_MUL: begin
					st_q <= rph_pkg::D_CMP;
				end
				rph_pkg::D_CMP: begin
					if (in_rng) begin
						st_q <= rph_pkg::D_STEP;
					end else begin
						st_q   <= rph_pkg::D_IDLE;
						done_q <= 1'b1;
						hit_q  <= 1'b0;
					end
				end
				rph_pkg::D_STEP: begin
					if (step_q == STEP_W'(IDX_W - 1)) begin
						st_q   <= rph_pkg::D_IDLE;
						done_q <= 1'b1;
						hit_q  <= 1'b1;
					end
				end
				default: begin
					st_q <= rph_pkg::D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			rph_pkg::D_IDLE: begin
				if (start) begin
					rem_q   <= mag;
					width_q <= width;
					lim_q   <= lim;
				end
			end
			rph_pkg::D_MUL: begin
				prod_q <= width_q * lim_q;
			end
			rph_pkg::D_CMP: begin
				// quotient is known to fit IDX_W bits once in range
				dsh_q  <= DSH_W'(width_q) << (IDX_W - 1);
				step_q <= '0;
				quot_q <= '0;
			end
			rph_pkg::D_STEP: begin
				if (ge) rem_q <= rem_q - dsh_q[rph_pkg::POS_W-1:0];
				quot_q <= IDX_W'({quot_q, ge});
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stat.done = done_q;
	assign stat.hit  = hit_q;
	assign quot      = quot_q;

endmodule

/* src/rph_mem.sv */
// Bin counter store: one write port, one read port, registered read data.
// No dependencies.
module rph_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rd_q <= mem_q[raddr];
	end

	assign rd_data = rd_q;

endmodule

/* src/radial_position_histogram.sv */
// Histogram of particle positions over fixed-width bins. Depends on rph_pkg,
// rph_div and rph_mem.
//
// After reset the block clears its MAX_BINS counters, one per cycle, and
// takes no item until the clear is done; configuration writes are taken
// throughout. It then works on one item at a time. A read or read-and-clear
// item goes through a memory read and then its result, with a zero written
// back for read-and-clear. For an accumulate item that lands in a bin, the
// bin index is found one quotient bit per cycle after a width*count range
// multiply, then the counter goes through a read-modify-write. An accumulate
// item that falls outside the bins skips the memory. A finished result waits
// in the output register while the next item is already being worked on.
module radial_position_histogram #(
	parameter int MAX_BINS   = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[31:0], read_index[39:32]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // bin_index[7:0], count[39:8]
	output logic [0:0]  m_tuser,   // in_range[0]
	input  logic        cfg_we,
	input  logic [rph_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rph_pkg::WIDTH_W-1:0]   cfg_wdata
);

	localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int LIM_W = IDX_W + 1;

	rph_pkg::state_t state_q;
	rph_pkg::op_t    op_q;
	rph_pkg::div_stat_t div_stat;

	logic [rph_pkg::WIDTH_W-1:0]   bin_width_q;
	logic [rph_pkg::BCNT_W-1:0]    bin_count_q;
	logic [rph_pkg::POS_W-1:0]     in_mag;
	logic [rph_pkg::RIDX_W-1:0]    in_ridx;
	logic [IDX_W-1:0]              addr_q;
	logic [IDX_W-1:0]              clr_q;
	logic [rph_pkg::OUT_IDX_W-1:0] res_idx_q;
	logic [LIM_W-1:0]              lim;
	logic [IDX_W-1:0]              quot;
	logic                          accept;
	logic                          out_free;
	logic                          res_done;
	logic                          ridx_ok;

	logic                          m_tvalid_q;
	logic [rph_pkg::OUT_IDX_W-1:0] out_idx_q;
	logic                          out_hit_q;
	logic [rph_pkg::OUT_CNT_W-1:0] out_cnt_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] inc;

	assign s_tready = (state_q == rph_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign res_done = out_free && (state_q inside {rph_pkg::ST_MOD, rph_pkg::ST_EMIT});
	assign in_mag   = s_tdata[31] ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];
	assign in_ridx  = s_tdata[39:32];
	assign ridx_ok  = 32'(in_ridx) < 32'(MAX_BINS);
	assign lim      = (32'(bin_count_q) > 32'(MAX_BINS)) ? LIM_W'(MAX_BINS)
	                                                     : LIM_W'(bin_count_q);
	// saturate at the counter's largest value
	assign inc      = (&rd_data) ? rd_data : rd_data + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= 32'd65536;
			bin_count_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				rph_pkg::CFG_BIN_WIDTH: bin_width_q <= cfg_wdata;
				rph_pkg::CFG_BIN_COUNT: bin_count_q <= cfg_wdata[rph_pkg::BCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rph_div #(
		.IDX_W (IDX_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && (rph_pkg::op_t'(s_tuser) == rph_pkg::OP_ACC)),
		.mag    (in_mag),
		.width  (bin_width_q),
		.lim    (lim),
		.stat   (div_stat),
		.quot   (quot)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_re    = (state_q == rph_pkg::ST_READ);
		if (state_q == rph_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (state_q == rph_pkg::ST_MOD && out_free &&
		             op_q != rph_pkg::OP_READ) begin
			mem_we    = 1'b1;
			mem_wdata = (op_q == rph_pkg::OP_ACC) ? inc : '0;
		end
	end

	rph_mem #(
		.DEPTH (MAX_BINS),
		.AW    (IDX_W),
		.DW    (COUNT_BITS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr   (addr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rph_pkg::ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_done) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				rph_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(MAX_BINS - 1)) state_q <= rph_pkg::ST_IDLE;
				end
				rph_pkg::ST_IDLE: begin
					if (accept) begin
						case (rph_pkg::op_t'(s_tuser))
							rph_pkg::OP_ACC: state_q <= rph_pkg::ST_DIV;
							rph_pkg::OP_READ, rph_pkg::OP_RDCLR: begin
								state_q <= ridx_ok ? rph_pkg::ST_READ : rph_pkg::ST_EMIT;
							end
							default: state_q <= rph_pkg::ST_EMIT;
						endcase
					end
				end
				rph_pkg::ST_DIV: begin
					if (div_stat.done)
						state_q <= div_stat.hit ? rph_pkg::ST_READ : rph_pkg::ST_EMIT;
				end
				rph_pkg::ST_READ: begin
					state_q <= rph_pkg::ST_MOD;
				end
				rph_pkg::ST_MOD, rph_pkg::ST_EMIT: begin
					// hold until the output register has room
					if (out_free) state_q <= rph_pkg::ST_IDLE;
				end
				default: begin
					state_q <= rph_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= rph_pkg::op_t'(s_tuser);
			case (rph_pkg::op_t'(s_tuser))
				rph_pkg::OP_READ, rph_pkg::OP_RDCLR: begin
					addr_q    <= IDX_W'(in_ridx);
					res_idx_q <= in_ridx;
				end
				default: begin
					res_idx_q <= '0;
				end
			endcase
		end
		if (state_q == rph_pkg::ST_DIV && div_stat.done && div_stat.hit) addr_q <= quot;
		if (out_free) begin
			if (state_q == rph_pkg::ST_MOD) begin
				out_idx_q <= rph_pkg::OUT_IDX_W'(addr_q);
				out_hit_q <= (op_q == rph_pkg::OP_ACC);
				out_cnt_q <= (op_q == rph_pkg::OP_ACC) ? rph_pkg::OUT_CNT_W'(inc)
				                                       : rph_pkg::OUT_CNT_W'(rd_data);
			end else if (state_q == rph_pkg::ST_EMIT) begin
				out_idx_q <= res_idx_q;
				out_hit_q <= 1'b0;
				out_cnt_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_cnt_q, out_idx_q};
	assign m_tuser  = out_hit_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == rph_pkg::ST_DIV))
		else $error("divider finished outside the index search");

	a_nonzero_write_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_wdata != '0) |-> (state_q == rph_pkg::ST_MOD && op_q == rph_pkg::OP_ACC))
		else $error("counter written with a non-zero value outside accumulate");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in flight");

endmodule

/* test/radial_position_histogram_tb.sv */
// Self-checking testbench for radial_position_histogram: directed table, then random phases.
// Depends on rph_pkg and the block itself; keeps its own bin model and checks every result.
module radial_position_histogram_tb;

	localparam int NBINS    = 256;
	localparam int NPHASES  = 10;
	localparam int PHASE_N  = 115;
	localparam int DRAIN    = 20;
	localparam int HOLD_LEN = 200;
	localparam int NROWS    = 30;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [7:0]  idx;
		logic        hit;
		logic [31:0] cnt;
	} bin_res_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic [rph_pkg::CFG_IDX_W-1:0] reg_sel;
		rph_pkg::op_t                  op;
		logic [31:0]                   val;
		logic [7:0]                    ridx;
		logic                          typed;
		bin_res_t                      want;
	} row_t;

	localparam bin_res_t NO_RES    = '0;
	localparam bin_res_t TOP_EMPTY = '{8'd255, 1'b0, 32'd0};
	localparam bin_res_t BIN0_ONE  = '{8'd0, 1'b1, 32'd1};
	localparam bin_res_t BIN0_TWO  = '{8'd0, 1'b1, 32'd2};

	// val holds the position for items and the register value for writes
	localparam row_t SCRIPT [NROWS] = '{
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_READ,  32'h0000_0000, 8'd0,   1'b1, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_READ,  32'h0000_0000, 8'd255, 1'b1, TOP_EMPTY},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_NONE,  32'hFFFF_FFFF, 8'd255, 1'b1, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0000_0000, 8'd0,   1'b1, BIN0_ONE},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0000_FFFF, 8'd7,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'hFFFF_0000, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h00FF_FFFF, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0100_0000, 8'd0,   1'b1, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h7FFF_FFFF, 8'd0,   1'b1, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h8000_0000, 8'd0,   1'b1, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'hFF00_8000, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_RDCLR, 32'h0000_0000, 8'd255, 1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_READ,  32'h0000_0000, 8'd255, 1'b1, TOP_EMPTY},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_RDCLR, 32'h0000_0000, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_READ,  32'h0000_0000, 8'd1,   1'b0, NO_RES},
		// zero bin width: nothing lands in range
		'{ROW_CFG,  rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0000_0000, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0000_0000, 8'd0,   1'b1, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_READ,  32'h0000_0000, 8'd0,   1'b1, NO_RES},
		// zero bin count: nothing lands in range either
		'{ROW_CFG,  rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0000_0001, 8'd0,   1'b0, NO_RES},
		'{ROW_CFG,  rph_pkg::CFG_BIN_COUNT, rph_pkg::OP_ACC,   32'h0000_0000, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0000_0000, 8'd0,   1'b1, NO_RES},
		// count above the bin store is clipped to it
		'{ROW_CFG,  rph_pkg::CFG_BIN_COUNT, rph_pkg::OP_ACC,   32'h0000_01FF, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0000_00FF, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'hFFFF_FF00, 8'd0,   1'b1, NO_RES},
		// widest bin: both extreme positions land in the first bin
		'{ROW_CFG,  rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'hFFFF_FFFF, 8'd0,   1'b0, NO_RES},
		'{ROW_CFG,  rph_pkg::CFG_BIN_COUNT, rph_pkg::OP_ACC,   32'h0000_0001, 8'd0,   1'b0, NO_RES},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h8000_0000, 8'd0,   1'b1, BIN0_ONE},
		'{ROW_ITEM, rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h7FFF_FFFF, 8'd0,   1'b1, BIN0_TWO},
		'{ROW_CFG,  rph_pkg::CFG_BIN_WIDTH, rph_pkg::OP_ACC,   32'h0001_0000, 8'd0,   1'b0, NO_RES},
		'{ROW_CFG,  rph_pkg::CFG_BIN_COUNT, rph_pkg::OP_ACC,   32'h0000_0100, 8'd0,   1'b0, NO_RES}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [39:0]                   s_tdata = '0;   // position[31:0], read_index[39:32]
	logic [1:0]                    s_tuser = '0;   // opcode[1:0]
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [39:0]                   m_tdata;        // bin_index[7:0], count[39:8]
	logic [0:0]                    m_tuser;        // in_range[0]
	logic                          cfg_we = 1'b0;
	logic [rph_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rph_pkg::WIDTH_W-1:0]   cfg_wdata = '0;

	// shadow of the block's state and registers
	logic [31:0] bin_tally [NBINS];
	logic [31:0] bin_width;
	logic [8:0]  bin_count;

	bin_res_t bin_expect [$];
	bin_res_t head_res;

	int  fail_count;
	int  items_sent;
	int  results_checked;
	int  hits_seen;
	int  reg_writes;
	bit  steady;
	bit  rx_hold;

	radial_position_histogram DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int unsigned bin_limit();
		return (bin_count > NBINS) ? NBINS : bin_count;
	endfunction

	function automatic bin_res_t predict_bin(rph_pkg::op_t op, logic [31:0] pos,
			logic [7:0] ridx);
		bin_res_t    r;
		logic [31:0] mag;
		logic [31:0] q;
		r = '0;
		case (op)
			rph_pkg::OP_ACC: begin
				mag = pos[31] ? -pos : pos;
				if (bin_width != 0) begin
					q = mag / bin_width;
					if (q < bin_limit()) begin
						// saturate rather than wrap
						if (bin_tally[q[7:0]] != '1)
							bin_tally[q[7:0]] = bin_tally[q[7:0]] + 32'd1;
						r.idx = q[7:0];
						r.hit = 1'b1;
						r.cnt = bin_tally[q[7:0]];
					end
				end
			end
			rph_pkg::OP_READ, rph_pkg::OP_RDCLR: begin
				r.idx = ridx;
				r.cnt = bin_tally[ridx];
				if (op == rph_pkg::OP_RDCLR)
					bin_tally[ridx] = '0;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// positions aimed mostly inside the bins, some at the outer edge, some anywhere
	function automatic logic [31:0] pick_position();
		logic [63:0]  mag;
		int unsigned  lim;
		int unsigned  sel;
		lim = bin_limit();
		sel = $urandom_range(0, 9);
		if (bin_width == 0 || lim == 0 || sel >= 8)
			return $urandom();
		if (sel < 6)
			mag = 64'($urandom_range(0, lim - 1)) * 64'(bin_width)
				+ 64'($urandom_range(0, bin_width - 1));
		else
			mag = 64'(bin_width) * 64'(lim) + 64'($urandom_range(0, 2)) - 64'd1;
		if (mag > 64'h8000_0000)
			mag = 64'($urandom_range(0, 32'h8000_0000));
		if (mag == 64'h8000_0000)
			return 32'h8000_0000;
		return $urandom_range(0, 1) ? -mag[31:0] : mag[31:0];
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fail_count++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	task automatic send_item(rph_pkg::op_t op, logic [31:0] pos, logic [7:0] ridx,
			logic typed, bin_res_t want);
		int       gap;
		bin_res_t r;
		gap = steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {ridx, pos};
		// the offered item is the next one taken, so predict now
		r = predict_bin(op, pos, ridx);
		bin_expect.push_back(typed ? want : r);
		items_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(logic [rph_pkg::CFG_IDX_W-1:0] sel, logic [31:0] value);
		s_tvalid <= 1'b0;
		while (bin_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (sel)
			rph_pkg::CFG_BIN_WIDTH: bin_width = value;
			rph_pkg::CFG_BIN_COUNT: bin_count = value[8:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		forever begin
			gap = steady ? 0 : $urandom_range(0, 12);
			if (rx_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				rx_hold = 1'b0;
			end else if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (m_tuser[0])
				hits_seen++;
			if (bin_expect.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[39:8], 32'd0);
			end else begin
				head_res = bin_expect.pop_front();
				if (m_tdata[7:0] !== head_res.idx)
					report_mismatch("bin_index", 32'(m_tdata[7:0]), 32'(head_res.idx));
				if (m_tuser[0] !== head_res.hit)
					report_mismatch("in_range", 32'(m_tuser[0]), 32'(head_res.hit));
				if (m_tdata[39:8] !== head_res.cnt)
					report_mismatch("count", m_tdata[39:8], head_res.cnt);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("FAIL radial_position_histogram");
		$finish;
	end

	initial begin
		logic [31:0] w;
		logic [31:0] c;
		int          k;
		fail_count      = 0;
		items_sent      = 0;
		results_checked = 0;
		hits_seen       = 0;
		reg_writes      = 0;
		steady          = 1'b0;
		rx_hold         = 1'b0;
		bin_width       = 32'h0001_0000;
		bin_count       = 9'd256;
		foreach (bin_tally[i])
			bin_tally[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_CFG)
				write_reg(SCRIPT[i].reg_sel, SCRIPT[i].val);
			else
				send_item(SCRIPT[i].op, SCRIPT[i].val, SCRIPT[i].ridx,
					SCRIPT[i].typed, SCRIPT[i].want);
		end

		for (int ph = 0; ph < NPHASES; ph++) begin
			case (ph)
				0: begin w = 32'hFFFF_FFFF; c = 32'd2; end
				1: begin w = 32'd1; c = 32'd256; end
				2: begin w = 32'h0080_0000; c = 32'd256; end
				3: begin w = 32'h0001_0000; c = 32'd256; end
				default: begin
					k = $urandom_range(0, 9);
					if (k == 0)      w = 32'd0;
					else if (k == 1) w = $urandom_range(1, 255);
					else if (k < 7)  w = $urandom_range(32'h1000, 32'h4_0000);
					else if (k == 7) w = $urandom_range(32'h4_0000, 32'h100_0000);
					else if (k == 8) w = $urandom();
					else             w = 32'hFFFF_FFFF;
					k = $urandom_range(0, 19);
					if (k == 0)      c = 32'd0;
					else if (k < 3)  c = 32'd1;
					else if (k < 5)  c = $urandom_range(257, 511);
					else if (k < 9)  c = 32'd256;
					else             c = $urandom_range(2, 255);
				end
			endcase
			write_reg(rph_pkg::CFG_BIN_WIDTH, w);
			write_reg(rph_pkg::CFG_BIN_COUNT, c);
			// stall the output long enough to back the block up
			if (ph == 3)
				rx_hold = 1'b1;
			for (int n = 0; n < PHASE_N; n++) begin
				steady = ((n / 40) % 3) == 1;
				k = $urandom_range(0, 19);
				if (k < 13)
					send_item(rph_pkg::OP_ACC, pick_position(), 8'($urandom()), 1'b0, NO_RES);
				else if (k < 16)
					send_item(rph_pkg::OP_READ, $urandom(), 8'($urandom()), 1'b0, NO_RES);
				else if (k < 19)
					send_item(rph_pkg::OP_RDCLR, $urandom(), 8'($urandom()), 1'b0, NO_RES);
				else
					send_item(rph_pkg::OP_NONE, $urandom(), 8'($urandom()), 1'b0, NO_RES);
			end
			steady = 1'b0;
		end

		s_tvalid <= 1'b0;
		while (bin_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Ran %0d items through %0d register writes, including zero and clipped settings.",
			items_sent, reg_writes);
		$display("Checked %0d results, %0d of them in-range accumulates; %0d mismatches.",
			results_checked, hits_seen, fail_count);
		if (fail_count == 0)
			$display("PASS radial_position_histogram");
		else
			$display("FAIL radial_position_histogram");
		$finish;
	end

endmodule

/* sim.f */
src/rph_pkg.sv
src/rph_div.sv
src/rph_mem.sv
src/radial_position_histogram.sv
test/radial_position_histogram_tb.sv
